// ----- hw/rtl/c24alu_pkg.sv -----
// package for the checked integer alu: widths, operation and status codes
// no dependencies
`timescale 1ns / 1ps
package c24alu_pkg;
   localparam int DATA_WIDTH_DEFAULT = 24;
   localparam int EXP_WIDTH_DEFAULT  = 32;
   localparam int MODE_WIDTH         = 3;
   localparam int STATUS_WIDTH       = 2;

   localparam logic [MODE_WIDTH-1:0] MODE_ADD = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_SUB = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_MUL = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_DIV = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_POW = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OVF  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_DIV0 = 2'd2;
endpackage

// ----- hw/rtl/c24alu_if.sv -----
// valid/ready channel interfaces for request and response beats
// depends on c24alu_pkg
`timescale 1ns / 1ps
interface c24alu_req_if #(
   parameter int DATA_WIDTH = c24alu_pkg::DATA_WIDTH_DEFAULT,
   parameter int EXP_WIDTH  = c24alu_pkg::EXP_WIDTH_DEFAULT
);
   logic                                valid;
   logic                                ready;
   logic [c24alu_pkg::MODE_WIDTH-1:0]   mode;
   logic signed [DATA_WIDTH-1:0]        operand_a;
   logic signed [DATA_WIDTH-1:0]        operand_b;
   logic [EXP_WIDTH-1:0]                exponent;
   modport source (output valid, mode, operand_a, operand_b, exponent, input ready);
   modport sink (input valid, mode, operand_a, operand_b, exponent, output ready);
endinterface

interface c24alu_rsp_if #(
   parameter int DATA_WIDTH = c24alu_pkg::DATA_WIDTH_DEFAULT
);
   logic                                 valid;
   logic                                 ready;
   logic signed [DATA_WIDTH-1:0]         result;
   logic [c24alu_pkg::STATUS_WIDTH-1:0]  status;
   modport source (output valid, result, status, input ready);
   modport sink (input valid, result, status, output ready);
endinterface

// ----- hw/rtl/c24alu_mul.sv -----
// shift-add signed multiplier, one bit of the multiplier per cycle
// depends on c24alu_pkg for the default width
`timescale 1ns / 1ps
module c24alu_mul #(
   parameter int DATA_WIDTH = c24alu_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [DATA_WIDTH-1:0]    op_x,
   input  logic signed [DATA_WIDTH-1:0]    op_y,
   output logic                            done,
   output logic signed [2*DATA_WIDTH-1:0]  product
);
   localparam int PW = 2*DATA_WIDTH;
   localparam int CW = $clog2(DATA_WIDTH+1);

   logic                   busy_ff;
   logic [CW-1:0]          cnt_ff;
   logic [PW-1:0]          acc_ff, mcand_ff;
   logic [DATA_WIDTH-1:0]  mplier_ff;
   logic                   neg_ff;
   logic                   done_ff;
   logic [DATA_WIDTH-1:0]  abs_x, abs_y;

   assign abs_x = op_x[DATA_WIDTH-1] ? DATA_WIDTH'(-op_x) : op_x;
   assign abs_y = op_y[DATA_WIDTH-1] ? DATA_WIDTH'(-op_y) : op_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff   <= 1'b1;
            cnt_ff    <= CW'(DATA_WIDTH);
            acc_ff    <= '0;
            mcand_ff  <= PW'(abs_x);
            mplier_ff <= abs_y;
            neg_ff    <= op_x[DATA_WIDTH-1] ^ op_y[DATA_WIDTH-1];
         end else if (busy_ff) begin
            if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
            cnt_ff    <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);
endmodule

// ----- hw/rtl/c24alu_div.sv -----
// restoring divider on magnitudes, one quotient bit per cycle, truncating
// depends on c24alu_pkg for the default width
`timescale 1ns / 1ps
module c24alu_div #(
   parameter int DATA_WIDTH = c24alu_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [DATA_WIDTH-1:0]  op_n,
   input  logic signed [DATA_WIDTH-1:0]  op_d,
   output logic                          done,
   output logic signed [DATA_WIDTH:0]    quotient
);
   localparam int CW = $clog2(DATA_WIDTH+1);

   logic                   busy_ff, done_ff, neg_ff;
   logic [CW-1:0]          cnt_ff;
   logic [DATA_WIDTH-1:0]  q_ff, d_ff;
   logic [DATA_WIDTH:0]    rem_ff, trial;
   logic [DATA_WIDTH-1:0]  abs_n, abs_d;

   assign abs_n = op_n[DATA_WIDTH-1] ? DATA_WIDTH'(-op_n) : op_n;
   assign abs_d = op_d[DATA_WIDTH-1] ? DATA_WIDTH'(-op_d) : op_d;
   assign trial = {rem_ff[DATA_WIDTH-1:0], q_ff[DATA_WIDTH-1]} - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DATA_WIDTH);
            rem_ff  <= '0;
            q_ff    <= abs_n;
            d_ff    <= abs_d;
            neg_ff  <= op_n[DATA_WIDTH-1] ^ op_d[DATA_WIDTH-1];
         end else if (busy_ff) begin
            // dividend bits shift out of q while quotient bits shift in
            if (!trial[DATA_WIDTH]) begin
               rem_ff <= trial;
               q_ff   <= {q_ff[DATA_WIDTH-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[DATA_WIDTH-1:0], q_ff[DATA_WIDTH-1]};
               q_ff   <= {q_ff[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
endmodule

// ----- hw/rtl/checked_24bit_integer_alu.sv -----
// top level of the checked signed alu: sequencer, shared multiplier, divider
// depends on c24alu_pkg, c24alu_if, c24alu_mul, c24alu_div
`timescale 1ns / 1ps
// One beat at a time. Add and subtract finish in S_MUL_ONE, multiply and
// divide wait in S_WAIT for their bit-serial unit (a zero divisor skips it),
// and power takes up to 2*EXP_WIDTH-1 passes of the bit-serial multiplier (one
// multiply per set exponent bit, one square per bit below the top set bit).
// The multiplier's one-bit-per-cycle loop sets the rate. A finished result
// is held in an output register until taken; the next beat is accepted
// only after that.
module checked_24bit_integer_alu #(
   parameter int DATA_WIDTH = c24alu_pkg::DATA_WIDTH_DEFAULT,
   parameter int EXP_WIDTH  = c24alu_pkg::EXP_WIDTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   c24alu_req_if.sink   req,
   c24alu_rsp_if.source rsp
);
   localparam int PW = 2*DATA_WIDTH;
   localparam logic signed [PW-1:0] LIM_MIN = -(PW'(1) <<< (DATA_WIDTH-1));
   localparam logic signed [PW-1:0] LIM_MAX = (PW'(1) <<< (DATA_WIDTH-1)) - PW'(1);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL_ONE, S_DIV, S_POW_ACC, S_POW_SQ, S_WAIT, S_OUT
   } state_type;

   state_type                      state_ff;
   logic [c24alu_pkg::MODE_WIDTH-1:0] mode_ff;
   logic signed [DATA_WIDTH-1:0]   a_ff, b_ff, acc_ff;
   logic [EXP_WIDTH-1:0]           e_ff;
   logic                           sq_ff;  // current pass is a squaring
   logic signed [DATA_WIDTH-1:0]   res_ff;
   logic [c24alu_pkg::STATUS_WIDTH-1:0] st_ff;
   // a one-cycle launch pulse, registered with the sequencer
   logic                           mul_go_ff, div_go_ff;

   logic                           mul_done, div_done;
   logic signed [DATA_WIDTH-1:0]   mul_x, mul_y;
   logic signed [PW-1:0]           product;
   logic signed [DATA_WIDTH:0]     quotient;
   logic signed [PW-1:0]           sum_w;
   logic                           prod_ok, quo_ok, sum_ok;
   logic                           accept;

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.result = res_ff;
   assign rsp.status = st_ff;

   assign sum_w = (mode_ff == c24alu_pkg::MODE_SUB)
                  ? PW'(a_ff) - PW'(b_ff) : PW'(a_ff) + PW'(b_ff);
   assign sum_ok  = (sum_w >= LIM_MIN) && (sum_w <= LIM_MAX);
   assign prod_ok = (product >= LIM_MIN) && (product <= LIM_MAX);
   assign quo_ok  = (quotient >= $signed((DATA_WIDTH+1)'(LIM_MIN)))
                 && (quotient <= $signed((DATA_WIDTH+1)'(LIM_MAX)));

   assign mul_x = (mode_ff == c24alu_pkg::MODE_MUL) ? a_ff : (sq_ff ? a_ff : acc_ff);
   assign mul_y = (mode_ff == c24alu_pkg::MODE_MUL) ? b_ff : a_ff;

   c24alu_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
      .clock(clock), .reset(reset), .start(mul_go_ff),
      .op_x(mul_x), .op_y(mul_y), .done(mul_done), .product(product));

   c24alu_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
      .clock(clock), .reset(reset), .start(div_go_ff),
      .op_n(a_ff), .op_d(b_ff), .done(div_done), .quotient(quotient));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         mul_go_ff <= 1'b0;
         div_go_ff <= 1'b0;
      end else begin
         mul_go_ff <= 1'b0;
         div_go_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  mode_ff <= req.mode;
                  a_ff    <= req.operand_a;
                  b_ff    <= req.operand_b;
                  e_ff    <= req.exponent;
                  acc_ff  <= DATA_WIDTH'(1);
                  res_ff  <= '0;
                  st_ff   <= c24alu_pkg::STATUS_OK;
                  unique case (req.mode)
                     c24alu_pkg::MODE_ADD, c24alu_pkg::MODE_SUB:
                        state_ff <= S_MUL_ONE;
                     c24alu_pkg::MODE_MUL: begin
                        mul_go_ff <= 1'b1;
                        state_ff  <= S_WAIT;
                     end
                     c24alu_pkg::MODE_DIV: state_ff <= S_DIV;
                     c24alu_pkg::MODE_POW: state_ff <= S_POW_ACC;
                     default: state_ff <= S_OUT;
                  endcase
               end
            end
            S_MUL_ONE: begin
               // add or subtract finishes here
               res_ff   <= sum_ok ? DATA_WIDTH'(sum_w) : '0;
               st_ff    <= sum_ok ? c24alu_pkg::STATUS_OK : c24alu_pkg::STATUS_OVF;
               state_ff <= S_OUT;
            end
            S_DIV: begin
               if (b_ff == '0) begin
                  st_ff    <= c24alu_pkg::STATUS_DIV0;
                  state_ff <= S_OUT;
               end else begin
                  div_go_ff <= 1'b1;
                  state_ff  <= S_WAIT;
               end
            end
            S_POW_ACC: begin
               if (e_ff == '0) begin
                  res_ff   <= acc_ff;
                  state_ff <= S_OUT;
               end else if (e_ff[0]) begin
                  sq_ff     <= 1'b0;
                  mul_go_ff <= 1'b1;
                  state_ff  <= S_WAIT;
               end else begin
                  state_ff <= S_POW_SQ;
               end
            end
            S_POW_SQ: begin
               // square only while higher exponent bits remain
               if ((e_ff >> 1) == '0) begin
                  res_ff   <= acc_ff;
                  state_ff <= S_OUT;
               end else begin
                  sq_ff     <= 1'b1;
                  mul_go_ff <= 1'b1;
                  state_ff  <= S_WAIT;
               end
            end
            S_WAIT: begin
               if (mode_ff == c24alu_pkg::MODE_DIV) begin
                  if (div_done) begin
                     res_ff   <= quo_ok ? DATA_WIDTH'(quotient) : '0;
                     st_ff    <= quo_ok ? c24alu_pkg::STATUS_OK : c24alu_pkg::STATUS_OVF;
                     state_ff <= S_OUT;
                  end
               end else if (mul_done) begin
                  if (!prod_ok) begin
                     res_ff   <= '0;
                     st_ff    <= c24alu_pkg::STATUS_OVF;
                     state_ff <= S_OUT;
                  end else if (mode_ff == c24alu_pkg::MODE_MUL) begin
                     res_ff   <= DATA_WIDTH'(product);
                     state_ff <= S_OUT;
                  end else if (sq_ff) begin
                     a_ff     <= DATA_WIDTH'(product);
                     e_ff     <= e_ff >> 1;
                     state_ff <= S_POW_ACC;
                  end else begin
                     acc_ff   <= DATA_WIDTH'(product);
                     state_ff <= S_POW_SQ;
                  end
               end
            end
            S_OUT: begin
               if (rsp.ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- dv/checked_24bit_integer_alu_tb.sv -----
// testbench for checked_24bit_integer_alu: directed table, then random beats under idling
// depends on c24alu_pkg, c24alu_if and the alu top level
`timescale 1ns / 1ps
module checked_24bit_integer_alu_tb;
   localparam int DW = c24alu_pkg::DATA_WIDTH_DEFAULT;
   localparam int EW = c24alu_pkg::EXP_WIDTH_DEFAULT;
   localparam int MODE_WIDTH = c24alu_pkg::MODE_WIDTH;
   localparam int STATUS_WIDTH = c24alu_pkg::STATUS_WIDTH;
   localparam logic [MODE_WIDTH-1:0] MODE_ADD = c24alu_pkg::MODE_ADD;
   localparam logic [MODE_WIDTH-1:0] MODE_SUB = c24alu_pkg::MODE_SUB;
   localparam logic [MODE_WIDTH-1:0] MODE_MUL = c24alu_pkg::MODE_MUL;
   localparam logic [MODE_WIDTH-1:0] MODE_DIV = c24alu_pkg::MODE_DIV;
   localparam logic [MODE_WIDTH-1:0] MODE_POW = c24alu_pkg::MODE_POW;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK   = c24alu_pkg::STATUS_OK;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OVF  = c24alu_pkg::STATUS_OVF;
   localparam logic [STATUS_WIDTH-1:0] STATUS_DIV0 = c24alu_pkg::STATUS_DIV0;
   localparam logic [MODE_WIDTH-1:0] MODE_RSVD5 = 3'd5;
   localparam logic [MODE_WIDTH-1:0] MODE_RSVD6 = 3'd6;
   localparam logic [MODE_WIDTH-1:0] MODE_RSVD7 = 3'd7;
   localparam logic signed [DW-1:0] SMIN = -(2 ** (DW - 1));
   localparam logic signed [DW-1:0] SMAX = (2 ** (DW - 1)) - 1;
   localparam int N_RANDOM = 1000;

   typedef struct packed {
      logic signed [DW-1:0]   result;
      logic [STATUS_WIDTH-1:0] status;
   } alu_out_type;

   typedef struct {
      logic [MODE_WIDTH-1:0] mode;
      logic signed [DW-1:0]  a;
      logic signed [DW-1:0]  b;
      logic [EW-1:0]         e;
      bit                    typed;
      alu_out_type           want;
   } op_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   c24alu_req_if req_ch ();
   c24alu_rsp_if rsp_ch ();

   checked_24bit_integer_alu u_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   always #6 clock = ~clock;

   alu_out_type pending_q[$];
   int errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int snd_idle = 35;
   int rcv_idle = 84;
   bit hold_req = 1'b0;

   function automatic bit fits(longint v);
      return v >= longint'(SMIN) && v <= longint'(SMAX);
   endfunction

   function automatic alu_out_type alu_predict(logic [MODE_WIDTH-1:0] mode,
                                               logic signed [DW-1:0] a,
                                               logic signed [DW-1:0] b,
                                               logic [EW-1:0] e);
      longint va, vb, r, acc, base;
      bit ovf;
      alu_out_type o;
      va = a;
      vb = b;
      r = 0;
      ovf = 1'b0;
      o.status = STATUS_OK;
      case (mode)
         MODE_ADD: r = va + vb;
         MODE_SUB: r = va - vb;
         MODE_MUL: r = va * vb;
         MODE_DIV: begin
            if (vb == 0) o.status = STATUS_DIV0;
            else r = va / vb;
         end
         MODE_POW: begin
            acc = 1;
            base = va;
            for (int i = 0; i < EW; i++) begin
               if (e[i]) begin
                  acc = acc * base;
                  if (!fits(acc)) begin
                     ovf = 1'b1;
                     break;
                  end
               end
               // square only while higher exponent bits remain
               if (i + 1 < EW && (e >> (i + 1)) != 0) begin
                  base = base * base;
                  if (!fits(base)) begin
                     ovf = 1'b1;
                     break;
                  end
               end else begin
                  break;
               end
            end
            r = acc;
            if (ovf) o.status = STATUS_OVF;
         end
         default: r = 0;
      endcase
      if (o.status == STATUS_OK && !fits(r)) o.status = STATUS_OVF;
      o.result = (o.status == STATUS_OK) ? r[DW-1:0] : '0;
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("MISMATCH %s at %0t: got %0d expected %0d", what, $realtime, got, want);
   endtask

   task automatic send_op(logic [MODE_WIDTH-1:0] mode, logic signed [DW-1:0] a,
                          logic signed [DW-1:0] b, logic [EW-1:0] e,
                          bit typed, alu_out_type want);
      alu_out_type exp_beat;
      while ($urandom_range(99) < snd_idle) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.mode = mode;
      req_ch.operand_a = a;
      req_ch.operand_b = b;
      req_ch.exponent = e;
      req_ch.valid = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      exp_beat = typed ? want : alu_predict(mode, a, b, e);
      pending_q.insert(pending_q.size(), exp_beat);
      n_sent++;
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   function automatic logic signed [DW-1:0] rand_operand();
      case ($urandom_range(5))
         0: return SMIN;
         1: return SMAX;
         2: return DW'($signed($urandom_range(8)) - 4);
         3: return DW'($signed($urandom_range(8000)) - 4000);
         default: return DW'($urandom);
      endcase
   endfunction

   // receiver: random idling plus one long hold-off counted here
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            hold_left = 400;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = !($urandom_range(99) < rcv_idle);
         end
      end
   end

   // result beats against the oldest expectation
   always @(posedge clock) begin
      alu_out_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_q.size() == 0) begin
            report_mismatch("unexpected beat, result", rsp_ch.result, 0);
         end else begin
            want = pending_q.pop_front();
            n_checked++;
            if (rsp_ch.result !== want.result)
               report_mismatch("result", rsp_ch.result, want.result);
            if (rsp_ch.status !== want.status)
               report_mismatch("status", rsp_ch.status, want.status);
         end
      end
   end

   initial begin
      #(12.0 * 6_000_000);
      $display("checked_24bit_integer_alu verification failed");
      $finish;
   end

   initial begin
      op_row_type rows[$];
      logic [MODE_WIDTH-1:0] m;
      logic signed [DW-1:0] a, b;
      logic [EW-1:0] e;

      req_ch.valid = 1'b0;
      req_ch.mode = MODE_ADD;
      req_ch.operand_a = '0;
      req_ch.operand_b = '0;
      req_ch.exponent = '0;

      // typed rows carry an expected beat, the rest use the predictor
      rows = '{
         '{MODE_ADD, SMAX, 24'sd1, 0, 1, '{'0, STATUS_OVF}},
         '{MODE_ADD, SMIN, -24'sd1, 0, 1, '{'0, STATUS_OVF}},
         '{MODE_ADD, SMAX, SMIN, 0, 1, '{-24'sd1, STATUS_OK}},
         '{MODE_SUB, SMIN, 24'sd1, 0, 1, '{'0, STATUS_OVF}},
         '{MODE_SUB, 24'sd0, SMIN, 0, 1, '{'0, STATUS_OVF}},
         '{MODE_SUB, SMAX, SMAX, 0, 1, '{'0, STATUS_OK}},
         '{MODE_MUL, SMAX, 24'sd1, 0, 1, '{SMAX, STATUS_OK}},
         '{MODE_MUL, SMIN, -24'sd1, 0, 1, '{'0, STATUS_OVF}},
         '{MODE_MUL, 24'sd4096, 24'sd2048, 0, 1, '{'0, STATUS_OVF}},
         '{MODE_MUL, -24'sd4096, 24'sd2048, 0, 1, '{SMIN, STATUS_OK}},
         '{MODE_DIV, 24'sd77, 24'sd0, 0, 1, '{'0, STATUS_DIV0}},
         '{MODE_DIV, SMIN, -24'sd1, 0, 1, '{'0, STATUS_OVF}},
         '{MODE_DIV, -24'sd7, 24'sd2, 0, 1, '{-24'sd3, STATUS_OK}},
         '{MODE_DIV, SMIN, SMAX, 0, 0, '{'0, STATUS_OK}},
         '{MODE_POW, 24'sd0, 24'sd5, 0, 1, '{24'sd1, STATUS_OK}},
         '{MODE_POW, SMIN, 24'sd0, 0, 1, '{24'sd1, STATUS_OK}},
         '{MODE_POW, -24'sd2, 24'sd0, 23, 1, '{SMIN, STATUS_OK}},
         '{MODE_POW, 24'sd2, 24'sd0, 23, 1, '{'0, STATUS_OVF}},
         '{MODE_POW, -24'sd1, 24'sd0, 32'hFFFF_FFFF, 1, '{-24'sd1, STATUS_OK}},
         '{MODE_POW, 24'sd1, 24'sd0, 32'h8000_0000, 1, '{24'sd1, STATUS_OK}},
         '{MODE_POW, 24'sd203, 24'sd0, 3, 0, '{'0, STATUS_OK}},
         '{MODE_POW, 24'sd2, 24'sd0, 32'h8000_0000, 1, '{'0, STATUS_OVF}},
         '{MODE_RSVD5, SMAX, SMAX, 32'hFFFF_FFFF, 1, '{'0, STATUS_OK}},
         '{MODE_RSVD6, SMIN, SMIN, 0, 1, '{'0, STATUS_OK}},
         '{MODE_RSVD7, 24'sd5, 24'sd9, 7, 1, '{'0, STATUS_OK}}
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i])
         send_op(rows[i].mode, rows[i].a, rows[i].b, rows[i].e, rows[i].typed, rows[i].want);

      for (int k = 0; k < N_RANDOM; k++) begin
         if (k == N_RANDOM / 3) begin
            snd_idle = 84;
            rcv_idle = 35;
         end else if (k == 2 * N_RANDOM / 3) begin
            snd_idle = 0;
            rcv_idle = 0;
         end
         // sender pause until the block has drained
         if (k == N_RANDOM / 2) begin
            while (pending_q.size() != 0) @(negedge clock);
         end
         if (k == 3 * N_RANDOM / 4) hold_req = 1'b1;

         m = ($urandom_range(19) == 0) ? MODE_WIDTH'($urandom_range(7, 5))
                                       : MODE_WIDTH'($urandom_range(4));
         a = rand_operand();
         b = ($urandom_range(15) == 0) ? '0 : rand_operand();
         case ($urandom_range(5))
            0: e = $urandom;
            1: e = $urandom | 32'h8000_0000;
            default: e = $urandom_range(40);
         endcase
         if (m == MODE_POW && $urandom_range(2) == 0)
            a = DW'($signed($urandom_range(6)) - 3);
         send_op(m, a, b, e, 1'b0, '0);
      end

      while (pending_q.size() != 0) @(negedge clock);
      repeat (2 * EW * (DW + 2) + 50) @(negedge clock);

      $display("covered %0d beats: all modes incl. reserved, range extremes, divide by zero,",
               n_sent);
      $display("power edge exponents, both idle mixes, a long output stall; %0d results checked",
               n_checked);
      if (errors == 0 && pending_q.size() == 0) begin
         $display("checked_24bit_integer_alu verification clean");
      end else begin
         $display("checked_24bit_integer_alu verification failed");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
hw/rtl/c24alu_pkg.sv
hw/rtl/c24alu_if.sv
hw/rtl/c24alu_mul.sv
hw/rtl/c24alu_div.sv
hw/rtl/checked_24bit_integer_alu.sv
dv/checked_24bit_integer_alu_tb.sv
